[design/kvlt_pkg.sv]
package kvlt_pkg;

	// Field widths fixed by the item format
	localparam int unsigned KEY_W = 32;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned POS_W = 6;
	localparam int unsigned IDX_W = 6;

	// Command codes
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_READ   = 2'd3
	} kvlt_cmd_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_RANGE     = 2'd3
	} kvlt_status_t;

	// Request token walking down the row of cells.
	// For a read, key, value and occ are replaced by the entry contents on a hit.
	typedef struct packed {
		kvlt_cmd_t          cmd;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
		logic [POS_W-1:0]   pos;
		logic               hit;
		logic [IDX_W-1:0]   idx;
		logic               occ;
	} kvlt_tok_t;

endpackage

[design/kvlt_cell.sv]
module kvlt_cell #(
	parameter int unsigned CELL_IDX = 0,
	parameter int unsigned CNT_W    = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CNT_W-1:0]    count,
	input  logic                in_vld,
	input  kvlt_pkg::kvlt_tok_t in_tok,
	output logic                out_vld,
	output kvlt_pkg::kvlt_tok_t out_tok
);

	localparam logic [CNT_W-1:0]            MY_CNT = CNT_W'(CELL_IDX);
	localparam logic [kvlt_pkg::IDX_W-1:0]  MY_IDX = kvlt_pkg::IDX_W'(CELL_IDX);
	localparam bit                          POS_OK = (CELL_IDX < (1 << kvlt_pkg::POS_W));

	logic [kvlt_pkg::KEY_W-1:0] key_q;
	logic [kvlt_pkg::VAL_W-1:0] value_q;
	logic                       occ_q;
	logic                       vld_q;
	kvlt_pkg::kvlt_tok_t        tok_q;
	kvlt_pkg::kvlt_tok_t        tok_nxt;
	logic                       below;
	logic                       key_hit;
	logic                       ins_here;
	logic                       rm_here;

	// Decode this entry's part in the passing request
	assign below    = (MY_CNT < count);
	assign key_hit  = below && occ_q && (key_q == in_tok.key) && !in_tok.hit;
	assign ins_here = in_vld && (in_tok.cmd == kvlt_pkg::CMD_INSERT) && (MY_CNT == count);
	assign rm_here  = in_vld && (in_tok.cmd == kvlt_pkg::CMD_REMOVE) && key_hit;

	// Update the request as it passes this entry
	always_comb begin
		tok_nxt = in_tok;
		case (in_tok.cmd)
			kvlt_pkg::CMD_INSERT: begin
				if (MY_CNT == count) begin
					tok_nxt.hit = 1'b1;
					tok_nxt.idx = MY_IDX;
				end
			end
			kvlt_pkg::CMD_SEARCH, kvlt_pkg::CMD_REMOVE: begin
				if (key_hit) begin
					tok_nxt.hit = 1'b1;
					tok_nxt.idx = MY_IDX;
				end
			end
			kvlt_pkg::CMD_READ: begin
				if (POS_OK && below && (in_tok.pos == kvlt_pkg::POS_W'(CELL_IDX))) begin
					tok_nxt.hit   = 1'b1;
					tok_nxt.idx   = MY_IDX;
					tok_nxt.key   = key_q;
					tok_nxt.value = value_q;
					tok_nxt.occ   = occ_q;
				end
			end
			default: begin
				tok_nxt = in_tok;
			end
		endcase
	end

	// Hold the entry; write on insert, drop the mark on remove
	always_ff @(posedge clk) begin
		if (ins_here) begin
			key_q   <= in_tok.key;
			value_q <= in_tok.value;
			occ_q   <= 1'b1;
		end else if (rm_here) begin
			occ_q   <= 1'b0;
		end
	end

	// Advance the request valid to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	// Advance the request payload
	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
	end

	assign out_vld = vld_q;
	assign out_tok = tok_q;

endmodule

[design/key_value_list_table_core.sv]
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tuser: command; s_tdata: key, value, position
// m        out  m_tvalid/m_tready  m_tuser: status; m_tdata: index, key_out, value_out,
//                                  occupied_out
//
// Every request walks the full row of TABLE_DEPTH entry cells, one cell per cycle,
// and its result is then registered in the output register.
// One request is in flight at a time; the next is taken at the earliest in the
// cycle its predecessor's result is taken.
// Reset clears the fill count and the request valids; entry contents are not
// cleared and only entries below the fill count are ever looked at.
// A stalled result holds in the output register and blocks new requests.
module key_value_list_table_core #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,  // [1:0] command
	input  logic [71:0] s_tdata,  // [31:0] key, [63:32] value, [69:64] position, [71:70] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,  // [1:0] status
	output logic [71:0] m_tdata   // [5:0] index, [37:6] key_out, [69:38] value_out,
	                              // [70] occupied_out, [71] zero
);

	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	logic                       chain_vld [0:TABLE_DEPTH];
	kvlt_pkg::kvlt_tok_t        chain_tok [0:TABLE_DEPTH];
	logic [CNT_W-1:0]           count_q;
	logic                       busy_q;
	logic                       m_vld_q;
	kvlt_pkg::kvlt_status_t     status_q;
	logic [kvlt_pkg::IDX_W-1:0] index_q;
	logic [kvlt_pkg::KEY_W-1:0] key_out_q;
	logic [kvlt_pkg::VAL_W-1:0] value_out_q;
	logic                       occ_out_q;
	logic                       s_acc;
	logic                       done;
	kvlt_pkg::kvlt_tok_t        last_tok;
	kvlt_pkg::kvlt_status_t     status_nxt;
	logic                       is_read;

	// Take a request when idle and the output register is free or draining
	assign s_tready = !busy_q && (!m_vld_q || m_tready);
	assign s_acc    = s_tvalid && s_tready;

	// Build the request token at the head of the row
	assign chain_vld[0]     = s_acc;
	assign chain_tok[0].cmd   = kvlt_pkg::kvlt_cmd_t'(s_tuser);
	assign chain_tok[0].key   = s_tdata[31:0];
	assign chain_tok[0].value = s_tdata[63:32];
	assign chain_tok[0].pos   = s_tdata[69:64];
	assign chain_tok[0].hit   = 1'b0;
	assign chain_tok[0].idx   = '0;
	assign chain_tok[0].occ   = 1'b0;

	// Row of entry cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		kvlt_cell #(
			.CELL_IDX (i),
			.CNT_W    (CNT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.count   (count_q),
			.in_vld  (chain_vld[i]),
			.in_tok  (chain_tok[i]),
			.out_vld (chain_vld[i+1]),
			.out_tok (chain_tok[i+1])
		);
	end

	assign done     = chain_vld[TABLE_DEPTH];
	assign last_tok = chain_tok[TABLE_DEPTH];
	assign is_read  = (last_tok.cmd == kvlt_pkg::CMD_READ);

	// Map the finished request to a status
	always_comb begin
		status_nxt = kvlt_pkg::ST_OK;
		if (!last_tok.hit) begin
			case (last_tok.cmd)
				kvlt_pkg::CMD_INSERT: status_nxt = kvlt_pkg::ST_FULL;
				kvlt_pkg::CMD_SEARCH: status_nxt = kvlt_pkg::ST_NOT_FOUND;
				kvlt_pkg::CMD_REMOVE: status_nxt = kvlt_pkg::ST_NOT_FOUND;
				kvlt_pkg::CMD_READ:   status_nxt = kvlt_pkg::ST_RANGE;
				default:              status_nxt = kvlt_pkg::ST_OK;
			endcase
		end
	end

	// Track the in-flight request, output valid and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			m_vld_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (s_acc) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				m_vld_q <= 1'b1;
			end else if (m_tready) begin
				m_vld_q <= 1'b0;
			end
			if (done && last_tok.hit && (last_tok.cmd == kvlt_pkg::CMD_INSERT)) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Capture the result payload
	always_ff @(posedge clk) begin
		if (done) begin
			status_q    <= status_nxt;
			index_q     <= last_tok.hit ? last_tok.idx : '0;
			key_out_q   <= (is_read && last_tok.hit) ? last_tok.key : '0;
			value_out_q <= (is_read && last_tok.hit) ? last_tok.value : '0;
			occ_out_q   <= is_read && last_tok.hit && last_tok.occ;
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {1'b0, occ_out_q, value_out_q, key_out_q, index_q};

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned TABLE_DEPTH = 64;

	// One reply as the block should return it
	typedef struct {
		kvlt_pkg::kvlt_status_t     status;
		logic [kvlt_pkg::IDX_W-1:0] idx;
		logic [kvlt_pkg::KEY_W-1:0] key;
		logic [kvlt_pkg::VAL_W-1:0] value;
		logic                       occ;
	} table_reply_t;

	// Shadow of the entry table: works out each reply and checks the ones returned
	class kv_table_shadow;
		logic [kvlt_pkg::KEY_W-1:0] keys [TABLE_DEPTH];
		logic [kvlt_pkg::VAL_W-1:0] vals [TABLE_DEPTH];
		bit                         marks [TABLE_DEPTH];
		int unsigned                fill;
		int unsigned                taken;
		int unsigned                mismatches;
		table_reply_t               awaited_replies [$];

		function new();
			fill = 0;
			taken = 0;
			mismatches = 0;
		endfunction

		// Apply one accepted request to the shadow table and queue its reply
		function void take_request(kvlt_pkg::kvlt_cmd_t cmd, logic [kvlt_pkg::KEY_W-1:0] key,
			logic [kvlt_pkg::VAL_W-1:0] value, logic [kvlt_pkg::POS_W-1:0] pos);
			table_reply_t r;
			r.status = kvlt_pkg::ST_OK;
			r.idx = '0;
			r.key = '0;
			r.value = '0;
			r.occ = 1'b0;
			case (cmd)
				kvlt_pkg::CMD_INSERT: begin
					if (fill >= TABLE_DEPTH) begin
						r.status = kvlt_pkg::ST_FULL;
					end else begin
						keys[fill] = key;
						vals[fill] = value;
						marks[fill] = 1'b1;
						r.idx = kvlt_pkg::IDX_W'(fill);
						fill++;
					end
				end
				kvlt_pkg::CMD_SEARCH, kvlt_pkg::CMD_REMOVE: begin
					// lowest occupied entry with a matching key wins
					r.status = kvlt_pkg::ST_NOT_FOUND;
					for (int unsigned i = 0; i < fill; i++) begin
						if (marks[i] && keys[i] == key) begin
							r.status = kvlt_pkg::ST_OK;
							r.idx = kvlt_pkg::IDX_W'(i);
							if (cmd == kvlt_pkg::CMD_REMOVE)
								marks[i] = 1'b0;
							break;
						end
					end
				end
				kvlt_pkg::CMD_READ: begin
					if (pos < fill) begin
						r.idx = pos;
						r.key = keys[pos];
						r.value = vals[pos];
						r.occ = marks[pos];
					end else begin
						r.status = kvlt_pkg::ST_RANGE;
					end
				end
				default: begin
					r.status = kvlt_pkg::ST_OK;
				end
			endcase
			awaited_replies.push_back(r);
			taken++;
		endfunction

		function int unsigned waiting();
			return awaited_replies.size();
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] reply check: %s", $time, msg);
			mismatches++;
		endtask

		// Compare one returned reply with the oldest one awaited
		task check_reply(kvlt_pkg::kvlt_status_t status, logic [kvlt_pkg::IDX_W-1:0] idx,
			logic [kvlt_pkg::KEY_W-1:0] key, logic [kvlt_pkg::VAL_W-1:0] value, logic occ);
			table_reply_t w;
			if (awaited_replies.size() == 0) begin
				report_mismatch($sformatf("unrequested reply, status %0d index %0d",
					status, idx));
				return;
			end
			w = awaited_replies.pop_front();
			if (status !== w.status)
				report_mismatch($sformatf("status %0d, wanted %0d", status, w.status));
			if (idx !== w.idx)
				report_mismatch($sformatf("index %0d, wanted %0d", idx, w.idx));
			if (key !== w.key)
				report_mismatch($sformatf("key_out %h, wanted %h", key, w.key));
			if (value !== w.value)
				report_mismatch($sformatf("value_out %h, wanted %h", value, w.value));
			if (occ !== w.occ)
				report_mismatch($sformatf("occupied_out %b, wanted %b", occ, w.occ));
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = '0;   // [1:0] command
	logic [71:0] s_tdata = '0;   // [31:0] key, [63:32] value, [69:64] position, [71:70] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [1:0]  m_tuser;        // [1:0] status
	logic [71:0] m_tdata;        // [5:0] index, [37:6] key_out, [69:38] value_out,
	                             // [70] occupied_out, [71] zero

	kv_table_shadow             tbl_shadow = new();
	logic [kvlt_pkg::KEY_W-1:0] key_pool [$];
	bit                         quiet_stretch = 1'b0;
	bit                         long_hold_done = 1'b0;

	key_value_list_table_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mostly short idle gaps, a few long ones, none during a quiet stretch
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet_stretch)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 5);
		return $urandom_range(20, 90);
	endfunction

	// Favor keys already stored so that searches and removes hit
	function automatic logic [kvlt_pkg::KEY_W-1:0] pick_key();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 65 && key_pool.size() > 0)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		if (r < 75) begin
			case ($urandom_range(3))
				0: return 32'h0000_0000;
				1: return 32'h8000_0000;
				2: return 32'h7fff_ffff;
				default: return 32'hffff_ffff;
			endcase
		end
		return $urandom();
	endfunction

	// Offer one request and hold it until taken
	task automatic offer_request(kvlt_pkg::kvlt_cmd_t cmd, logic [kvlt_pkg::KEY_W-1:0] key,
		logic [kvlt_pkg::VAL_W-1:0] value, logic [kvlt_pkg::POS_W-1:0] pos);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {2'b00, pos, value, key};
		do @(posedge clk); while (!s_tready);
		tbl_shadow.take_request(cmd, key, value, pos);
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering until every reply is back
	task automatic drain_replies();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tbl_shadow.waiting() != 0)
			@(posedge clk);
	endtask

	// Check every reply taken
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tbl_shadow.check_reply(kvlt_pkg::kvlt_status_t'(m_tuser), m_tdata[5:0],
				m_tdata[37:6], m_tdata[69:38], m_tdata[70]);
	end

	// Reply side: random ready spans and stalls, one long hold-off to back up the input
	initial begin
		int unsigned span;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!long_hold_done && tbl_shadow.taken >= 300) begin
				m_tready <= 1'b0;
				repeat (600) @(posedge clk);
				long_hold_done = 1'b1;
			end else begin
				m_tready <= 1'b1;
				span = quiet_stretch ? 50 : $urandom_range(1, 30);
				repeat (span) @(posedge clk);
				span = pick_gap();
				if (span != 0) begin
					m_tready <= 1'b0;
					repeat (span) @(posedge clk);
				end
			end
		end
	end

	// Request side
	initial begin
		kvlt_pkg::kvlt_cmd_t        cmd;
		logic [kvlt_pkg::KEY_W-1:0] k;
		logic [kvlt_pkg::VAL_W-1:0] v;
		logic [kvlt_pkg::POS_W-1:0] p;
		int unsigned                r;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: read past fill, key absent
		offer_request(kvlt_pkg::CMD_READ,   32'h0000_0000, $urandom(), 6'd0);
		offer_request(kvlt_pkg::CMD_SEARCH, 32'h0000_0000, $urandom(), 6'd63);
		offer_request(kvlt_pkg::CMD_REMOVE, 32'h7fff_ffff, $urandom(), 6'd0);
		// extreme keys and values, then a duplicate key
		offer_request(kvlt_pkg::CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff, 6'd63);
		offer_request(kvlt_pkg::CMD_INSERT, 32'h7fff_ffff, 32'h8000_0000, 6'd0);
		offer_request(kvlt_pkg::CMD_INSERT, 32'h0000_0000, 32'hffff_ffff, 6'd21);
		offer_request(kvlt_pkg::CMD_INSERT, 32'hffff_ffff, 32'h0000_0000, 6'd42);
		offer_request(kvlt_pkg::CMD_INSERT, 32'h8000_0000, 32'h1234_5678, 6'd0);
		// lowest match first; removed slot skipped, then key absent
		offer_request(kvlt_pkg::CMD_SEARCH, 32'h8000_0000, $urandom(), 6'd0);
		offer_request(kvlt_pkg::CMD_REMOVE, 32'h8000_0000, $urandom(), 6'd0);
		offer_request(kvlt_pkg::CMD_SEARCH, 32'h8000_0000, $urandom(), 6'd0);
		offer_request(kvlt_pkg::CMD_READ,   $urandom(), $urandom(), 6'd0);
		offer_request(kvlt_pkg::CMD_READ,   $urandom(), $urandom(), 6'd4);
		offer_request(kvlt_pkg::CMD_REMOVE, 32'h8000_0000, $urandom(), 6'd0);
		offer_request(kvlt_pkg::CMD_REMOVE, 32'h8000_0000, $urandom(), 6'd0);
		// reads at and beyond the fill count
		offer_request(kvlt_pkg::CMD_READ,   $urandom(), $urandom(), 6'd5);
		offer_request(kvlt_pkg::CMD_READ,   $urandom(), $urandom(), 6'd63);
		offer_request(kvlt_pkg::CMD_SEARCH, 32'hffff_ffff, $urandom(), 6'd0);
		offer_request(kvlt_pkg::CMD_READ,   $urandom(), $urandom(), 6'd3);
		drain_replies();

		key_pool = '{32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};

		// Random mix; the table fills early and stays full, so inserts then report full
		for (int unsigned n = 0; n < 1600; n++) begin
			quiet_stretch = ((n / 150) % 5 == 2);
			if (n == 800)
				drain_replies();
			r = $urandom_range(99);
			if (tbl_shadow.fill < TABLE_DEPTH)
				cmd = r < 35 ? kvlt_pkg::CMD_INSERT : r < 65 ? kvlt_pkg::CMD_SEARCH
					: r < 75 ? kvlt_pkg::CMD_REMOVE : kvlt_pkg::CMD_READ;
			else
				cmd = r < 6 ? kvlt_pkg::CMD_INSERT : r < 50 ? kvlt_pkg::CMD_SEARCH
					: r < 58 ? kvlt_pkg::CMD_REMOVE : kvlt_pkg::CMD_READ;
			v = ($urandom_range(19) == 0)
				? {1'($urandom_range(1)), {31{$urandom_range(1) == 1}}}
				: $urandom();
			p = kvlt_pkg::POS_W'($urandom_range(63));
			k = pick_key();
			if (cmd == kvlt_pkg::CMD_INSERT) begin
				if ($urandom_range(1) == 0)
					k = $urandom();
				key_pool.push_back(k);
			end else if (cmd == kvlt_pkg::CMD_READ) begin
				if (tbl_shadow.fill > 0 && $urandom_range(3) != 0)
					p = kvlt_pkg::POS_W'($urandom_range(0, tbl_shadow.fill - 1));
				k = $urandom();
			end
			offer_request(cmd, k, v, p);
		end
		quiet_stretch = 1'b0;
		s_tvalid <= 1'b0;

		// Let the last replies come back, then allow for stragglers
		while (tbl_shadow.waiting() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 16) @(posedge clk);
		if (tbl_shadow.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Stop a hung run
	initial begin
		#25_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
